// File: hdl/stgcd_pkg.sv
// ----------------------------------------------------------------------------
// stgcd_pkg: shared types and microcode for the range-GCD sparse table
// Field widths, action codes, control word layout and the control program
// that sequences element writes, table builds and range queries.
// ----------------------------------------------------------------------------
package stgcd_pkg;

	localparam int DEPTH_DEF  = 1024;
	localparam int LEVELS_DEF = 11;

	localparam int ACT_W = 2;
	localparam int IDX_W = 11;
	localparam int VAL_W = 31;
	localparam int GK_W  = 5;
	localparam int MSB_W = $clog2(IDX_W);

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// step labels of the control program
	localparam upc_t S_IDLE     = upc_t'(0);
	localparam upc_t S_B_INIT   = upc_t'(1);
	localparam upc_t S_B_CP_RD  = upc_t'(2);
	localparam upc_t S_B_CP_WR  = upc_t'(3);
	localparam upc_t S_B_LVL    = upc_t'(4);
	localparam upc_t S_B_RD_LO  = upc_t'(5);
	localparam upc_t S_B_RD_HI  = upc_t'(6);
	localparam upc_t S_B_LD_HI  = upc_t'(7);
	localparam upc_t S_B_GCD    = upc_t'(8);
	localparam upc_t S_B_WR     = upc_t'(9);
	localparam upc_t S_B_NEXT   = upc_t'(10);
	localparam upc_t S_Q_CHK    = upc_t'(11);
	localparam upc_t S_Q_RD_LO  = upc_t'(12);
	localparam upc_t S_Q_RD_HI  = upc_t'(13);
	localparam upc_t S_Q_LD_HI  = upc_t'(14);
	localparam upc_t S_Q_GCD    = upc_t'(15);
	localparam upc_t S_Q_EMIT   = upc_t'(16);

	typedef enum logic [2:0] {
		RD_NONE,
		RD_ELEM,
		RD_BLD_LO,
		RD_BLD_HI,
		RD_Q_LO,
		RD_Q_HI
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_COPY,
		WR_GCD
	} wr_sel_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_A,
		LD_B,
		LD_B_FAR
	} ld_sel_t;

	typedef enum logic [2:0] {
		CNT_NONE,
		CNT_BUILD_INIT,
		CNT_POS_INC,
		CNT_LVL_INC,
		CNT_QUERY
	} cnt_op_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_GCD,
		HOLD_OUT
	} hold_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_DISPATCH,
		JC_N_ZERO,
		JC_NOT_LAST,
		JC_LAST_LVL,
		JC_Q_ERR
	} jcond_t;

	typedef struct packed {
		rd_sel_t rd;
		wr_sel_t wr;
		ld_sel_t ld;
		cnt_op_t cnt;
		hold_t   hold;
		logic    emit;
		jcond_t  jc;
		upc_t    target;
	} uword_t;

	function automatic uword_t mk(rd_sel_t rd, wr_sel_t wr, ld_sel_t ld, cnt_op_t cnt,
			hold_t hold, logic emit, jcond_t jc, upc_t target);
		uword_t w;
		w.rd     = rd;
		w.wr     = wr;
		w.ld     = ld;
		w.cnt    = cnt;
		w.hold   = hold;
		w.emit   = emit;
		w.jc     = jc;
		w.target = target;
		return w;
	endfunction

	// control program ROM
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		case (pc)
			S_IDLE:    w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_NONE, HOLD_NONE, 1'b0,
					JC_DISPATCH, S_IDLE);
			S_B_INIT:  w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_BUILD_INIT, HOLD_NONE, 1'b0,
					JC_N_ZERO, S_IDLE);
			S_B_CP_RD: w = mk(RD_ELEM, WR_NONE, LD_NONE, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_B_CP_WR: w = mk(RD_NONE, WR_COPY, LD_NONE, CNT_POS_INC, HOLD_NONE, 1'b0,
					JC_NOT_LAST, S_B_CP_RD);
			S_B_LVL:   w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_LVL_INC, HOLD_NONE, 1'b0,
					JC_LAST_LVL, S_IDLE);
			S_B_RD_LO: w = mk(RD_BLD_LO, WR_NONE, LD_NONE, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_B_RD_HI: w = mk(RD_BLD_HI, WR_NONE, LD_A, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_B_LD_HI: w = mk(RD_NONE, WR_NONE, LD_B_FAR, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_B_GCD:   w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_NONE, HOLD_GCD, 1'b0,
					JC_NEVER, S_IDLE);
			S_B_WR:    w = mk(RD_NONE, WR_GCD, LD_NONE, CNT_POS_INC, HOLD_NONE, 1'b0,
					JC_NOT_LAST, S_B_RD_LO);
			S_B_NEXT:  w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_NONE, HOLD_NONE, 1'b0,
					JC_ALWAYS, S_B_LVL);
			S_Q_CHK:   w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_QUERY, HOLD_NONE, 1'b0,
					JC_Q_ERR, S_Q_EMIT);
			S_Q_RD_LO: w = mk(RD_Q_LO, WR_NONE, LD_NONE, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_Q_RD_HI: w = mk(RD_Q_HI, WR_NONE, LD_A, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_Q_LD_HI: w = mk(RD_NONE, WR_NONE, LD_B, CNT_NONE, HOLD_NONE, 1'b0,
					JC_NEVER, S_IDLE);
			S_Q_GCD:   w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_NONE, HOLD_GCD, 1'b0,
					JC_NEVER, S_IDLE);
			S_Q_EMIT:  w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_NONE, HOLD_OUT, 1'b1,
					JC_ALWAYS, S_IDLE);
			default:   w = mk(RD_NONE, WR_NONE, LD_NONE, CNT_NONE, HOLD_NONE, 1'b0,
					JC_ALWAYS, S_IDLE);
		endcase
		return w;
	endfunction

endpackage

// File: hdl/stgcd_if.sv
// ----------------------------------------------------------------------------
// stgcd_if: valid/ready channels of the range-GCD sparse table
// Request, response and configuration channels, each with a source and a
// sink modport.
// ----------------------------------------------------------------------------
interface stgcd_req_if import stgcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [IDX_W-1:0] index;
	logic [VAL_W-1:0] value;
	logic [IDX_W-1:0] left;
	logic [IDX_W-1:0] right;

	modport source (output valid, action, index, value, left, right, input ready);
	modport sink   (input valid, action, index, value, left, right, output ready);
endinterface

interface stgcd_rsp_if import stgcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] range_gcd;
	logic             error;

	modport source (output valid, range_gcd, error, input ready);
	modport sink   (input valid, range_gcd, error, output ready);
endinterface

interface stgcd_cfg_if import stgcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: hdl/stgcd_ram.sv
// ----------------------------------------------------------------------------
// stgcd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are undefined until
// written.
// ----------------------------------------------------------------------------
module stgcd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/sparse_table_range_gcd_core.sv
// ----------------------------------------------------------------------------
// sparse_table_range_gcd_core: range-GCD queries over a sparse table
// Element writes, table builds and queries run under a microcoded sequencer
// driving two RAMs and a binary GCD unit that takes one step per cycle.
// ----------------------------------------------------------------------------
// Write item: no result; ready stays high, so writes can follow back to back.
// Query item: range check, reads of both table entries, the GCD, then the result;
//   the next item is taken once the result is registered. A rejected range skips to the result.
// Build item: busy while it copies the n elements to level 0 and then fills each higher level,
//   one entry at a time; a result that waits on rsp.ready stalls the next one.
// Reset: sequencer idle, output empty, length 1; RAMs undefined, not cleared.
module sparse_table_range_gcd_core import stgcd_pkg::*; #(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	stgcd_cfg_if.sink   cfg,
	stgcd_req_if.sink   req,
	stgcd_rsp_if.source rsp
);

	localparam int AW     = $clog2(DEPTH);
	localparam int TDEPTH = DEPTH * LEVELS;
	localparam int TAW    = $clog2(TDEPTH);
	localparam int LW     = $clog2(LEVELS);
	localparam int SW     = ((AW > LEVELS) ? AW : LEVELS) + 1;
	localparam int QW     = ((IDX_W > LEVELS) ? IDX_W : LEVELS) + 1;

	uword_t uw;
	upc_t   upc_q;
	upc_t   upc_nxt;

	logic [IDX_W-1:0] length_q;
	logic [IDX_W-1:0] n_eff;
	logic [IDX_W-1:0] lt_q;
	logic [IDX_W-1:0] rt_q;
	logic [IDX_W-1:0] span;
	logic [MSB_W-1:0] span_msb;
	logic [AW-1:0]    pos_q;
	logic [LW-1:0]    lvl_q;
	logic [LW-1:0]    lvl_dn;
	logic [LW-1:0]    q_lvl;
	logic [SW-1:0]    half_sum;
	logic [QW-1:0]    q_hi_pos;
	logic             err_q;
	logic             qerr;
	logic             far;
	logic             pos_last;
	logic             last_lvl;
	logic             n_zero;

	logic             acc;
	logic             stall;
	logic             emit_fire;

	logic [VAL_W-1:0] ga_q;
	logic [VAL_W-1:0] gb_q;
	logic [GK_W-1:0]  gk_q;
	logic [VAL_W-1:0] ga_nx;
	logic [VAL_W-1:0] gb_nx;
	logic [GK_W-1:0]  gk_nx;
	logic             gcd_done;
	logic [VAL_W-1:0] gcd_res;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_gcd_q;
	logic             out_err_q;

	logic             elem_we;
	logic             elem_re;
	logic [AW-1:0]    elem_waddr;
	logic [VAL_W-1:0] elem_rdata;
	logic             tab_we;
	logic             tab_re;
	logic [TAW-1:0]   tab_waddr;
	logic [TAW-1:0]   tab_raddr;
	logic [VAL_W-1:0] tab_wdata;
	logic [VAL_W-1:0] tab_rdata;

	// level-major layout: one DEPTH-sized slab per level
	function automatic logic [TAW-1:0] taddr(logic [LW-1:0] l, logic [AW-1:0] p);
		return TAW'(l) * TAW'(DEPTH) + TAW'(p);
	endfunction

	assign uw = ucode(upc_q);

	// ---------------- status for the jump conditions ----------------
	assign n_eff    = (32'(length_q) > DEPTH) ? IDX_W'(DEPTH) : length_q;
	assign n_zero   = (n_eff == '0);
	assign pos_last = ((32'(pos_q) + 32'd1) == 32'(n_eff));
	assign last_lvl = (32'(lvl_q) == (LEVELS - 1));
	assign lvl_dn   = lvl_q - LW'(1);
	assign half_sum = SW'(pos_q) + (SW'(1) << lvl_dn);
	assign far      = (32'(half_sum) >= 32'(n_eff));

	assign qerr = (lt_q == '0) || (rt_q > n_eff) || (lt_q > rt_q);
	assign span = rt_q - lt_q + IDX_W'(1);

	always_comb begin
		span_msb = '0;
		for (int b = 0; b < IDX_W; b++) begin
			if (span[b]) begin
				span_msb = MSB_W'(b);
			end
		end
	end

	assign q_lvl    = (32'(span_msb) > (LEVELS - 1)) ? LW'(LEVELS - 1) : LW'(span_msb);
	assign q_hi_pos = QW'(rt_q) - (QW'(1) << lvl_q);

	// ---------------- GCD unit ----------------
	assign gcd_done = (ga_q == '0) || (gb_q == '0);
	assign gcd_res  = VAL_W'((ga_q | gb_q) << gk_q);

	always_comb begin
		ga_nx = ga_q;
		gb_nx = gb_q;
		gk_nx = gk_q;
		case ({ga_q[0], gb_q[0]})
			2'b00: begin
				ga_nx = ga_q >> 1;
				gb_nx = gb_q >> 1;
				gk_nx = gk_q + GK_W'(1);
			end
			2'b01: begin
				ga_nx = ga_q >> 1;
			end
			2'b10: begin
				gb_nx = gb_q >> 1;
			end
			default: begin
				if (ga_q >= gb_q) begin
					ga_nx = (ga_q - gb_q) >> 1;
				end else begin
					gb_nx = (gb_q - ga_q) >> 1;
				end
			end
		endcase
	end

	// ---------------- handshakes and stalls ----------------
	assign req.ready = (uw.jc == JC_DISPATCH);
	assign acc       = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign stall = ((uw.hold == HOLD_GCD) && !gcd_done) ||
		((uw.hold == HOLD_OUT) && out_valid_q && !rsp.ready);
	assign emit_fire = uw.emit && !stall;

	assign rsp.valid     = out_valid_q;
	assign rsp.range_gcd = out_gcd_q;
	assign rsp.error     = out_err_q;

	// ---------------- next step ----------------
	always_comb begin
		upc_nxt = upc_q + upc_t'(1);
		if (stall) begin
			upc_nxt = upc_q;
		end else begin
			case (uw.jc)
				JC_ALWAYS: begin
					upc_nxt = uw.target;
				end
				JC_DISPATCH: begin
					upc_nxt = S_IDLE;
					if (acc && (req.action == ACT_BUILD)) begin
						upc_nxt = S_B_INIT;
					end else if (acc && (req.action == ACT_QUERY)) begin
						upc_nxt = S_Q_CHK;
					end
				end
				JC_N_ZERO: begin
					if (n_zero) begin
						upc_nxt = uw.target;
					end
				end
				JC_NOT_LAST: begin
					if (!pos_last) begin
						upc_nxt = uw.target;
					end
				end
				JC_LAST_LVL: begin
					if (last_lvl) begin
						upc_nxt = uw.target;
					end
				end
				JC_Q_ERR: begin
					if (qerr) begin
						upc_nxt = uw.target;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- memory controls ----------------
	always_comb begin
		elem_re   = 1'b0;
		tab_re    = 1'b0;
		tab_raddr = '0;
		case (uw.rd)
			RD_ELEM: begin
				elem_re = 1'b1;
			end
			RD_BLD_LO: begin
				tab_re    = 1'b1;
				tab_raddr = taddr(lvl_dn, pos_q);
			end
			RD_BLD_HI: begin
				// past the length the entry is a plain copy: skip the read
				tab_re    = !far;
				tab_raddr = taddr(lvl_dn, AW'(half_sum));
			end
			RD_Q_LO: begin
				tab_re    = 1'b1;
				tab_raddr = taddr(lvl_q, pos_q);
			end
			RD_Q_HI: begin
				tab_re    = 1'b1;
				tab_raddr = taddr(lvl_q, AW'(q_hi_pos));
			end
			default: begin
			end
		endcase
	end

	assign elem_we = acc && (req.action == ACT_WRITE) && (req.index != '0) &&
		(32'(req.index) <= DEPTH);
	assign elem_waddr = AW'(req.index - IDX_W'(1));

	assign tab_we    = (uw.wr != WR_NONE) && !stall;
	assign tab_waddr = taddr(lvl_q, pos_q);
	assign tab_wdata = (uw.wr == WR_COPY) ? elem_rdata : gcd_res;

	stgcd_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (req.value),
		.re    (elem_re),
		.raddr (pos_q),
		.rdata (elem_rdata)
	);

	stgcd_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TDEPTH)
	) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (tab_re),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= S_IDLE;
			length_q    <= IDX_W'(1);
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			lvl_q       <= '0;
			err_q       <= 1'b0;
		end else begin
			upc_q <= upc_nxt;
			if (cfg.valid && cfg.ready) begin
				length_q <= cfg.data;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (!stall) begin
				case (uw.cnt)
					CNT_BUILD_INIT: begin
						pos_q <= '0;
						lvl_q <= '0;
					end
					CNT_POS_INC: begin
						pos_q <= pos_q + AW'(1);
					end
					CNT_LVL_INC: begin
						lvl_q <= lvl_q + LW'(1);
						pos_q <= '0;
					end
					CNT_QUERY: begin
						lvl_q <= q_lvl;
						pos_q <= AW'(lt_q - IDX_W'(1));
						err_q <= qerr;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (acc && (req.action == ACT_QUERY)) begin
			lt_q <= req.left;
			rt_q <= req.right;
		end
		case (uw.ld)
			LD_A: begin
				ga_q <= tab_rdata;
				gk_q <= '0;
			end
			LD_B: begin
				gb_q <= tab_rdata;
			end
			LD_B_FAR: begin
				// gcd(x, 0) = x turns the copy case into a GCD that takes no steps
				gb_q <= far ? '0 : tab_rdata;
			end
			default: begin
				if ((uw.hold == HOLD_GCD) && !gcd_done) begin
					ga_q <= ga_nx;
					gb_q <= gb_nx;
					gk_q <= gk_nx;
				end
			end
		endcase
		if (emit_fire) begin
			out_gcd_q <= err_q ? '0 : gcd_res;
			out_err_q <= err_q;
		end
	end

endmodule

// File: hdl/stgcd_chk.sv
// ----------------------------------------------------------------------------
// stgcd_chk: port-level checks for the range-GCD sparse table
// Watches the request and response channels of the core over time; bound
// to the core below.
// ----------------------------------------------------------------------------
module stgcd_chk import stgcd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic [ACT_W-1:0] req_action,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [VAL_W-1:0] rsp_range_gcd,
	input logic             rsp_error
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_gcd) && $stable(rsp_error))
		else $error("stgcd_chk: stalled result changed or dropped");

	// a query keeps the request side closed while it runs
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_action == ACT_QUERY) |=> !req_ready)
		else $error("stgcd_chk: item accepted right after a query");

	// a build keeps the request side closed while it runs
	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_action == ACT_BUILD) |=> !req_ready)
		else $error("stgcd_chk: item accepted right after a build");

	// no result can show up the cycle after a query is taken
	a_query_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_action == ACT_QUERY) |=> !$rose(rsp_valid))
		else $error("stgcd_chk: result appeared too early after a query");

endmodule

bind sparse_table_range_gcd_core stgcd_chk u_stgcd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_action    (req.action),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_range_gcd (rsp.range_gcd),
	.rsp_error     (rsp.error)
);
